// ----- rtl/core/tvc_pkg.sv -----
// Shared constants, codes and the command bundle of the tetrahedron volume classifier.
package tvc_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int THR_W = 52;
	localparam int VOL_OUT_W = 53;
	localparam int TOTAL_W = 32;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	localparam logic [1:0] POS_FIRST = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	localparam logic [1:0] MUL_FIRST = 2'd0;
	localparam logic [1:0] MUL_SECOND = 2'd1;
	localparam logic [1:0] MUL_OUTER = 2'd2;

	typedef struct packed {
		logic load_corner;
		logic [1:0] corner_sel;
		logic missing;
		logic clr_cnt;
		logic mul_en;
		logic [1:0] mul_sel;
		logic cross_load;
		logic cross_sub;
		logic vol_load;
		logic vol_add;
		logic rotate;
		logic mag_en;
		logic classify;
	} dp_cmd_t;

endpackage

// ----- rtl/core/tvc_corner_if.sv -----
// Request channel that carries one tetrahedron corner.
interface tvc_corner_if #(
	parameter int COORD_WIDTH = tvc_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] corner_x;
	logic signed [COORD_WIDTH-1:0] corner_y;
	logic signed [COORD_WIDTH-1:0] corner_z;
	logic corner_present;
	logic start_of_mesh;

	modport source (output valid, corner_x, corner_y, corner_z, corner_present,
		start_of_mesh, input ready);
	modport sink (input valid, corner_x, corner_y, corner_z, corner_present,
		start_of_mesh, output ready);
endinterface

// ----- rtl/core/tvc_result_if.sv -----
// Request channel that carries one volume classification result.
interface tvc_result_if;
	logic valid;
	logic ready;
	logic signed [tvc_pkg::VOL_OUT_W-1:0] six_volume;
	logic is_degenerate;
	logic is_inverted;
	logic bad_reference;
	logic [tvc_pkg::TOTAL_W-1:0] degenerate_total;
	logic [tvc_pkg::TOTAL_W-1:0] inverted_total;

	modport source (output valid, six_volume, is_degenerate, is_inverted, bad_reference,
		degenerate_total, inverted_total, input ready);
	modport sink (input valid, six_volume, is_degenerate, is_inverted, bad_reference,
		degenerate_total, inverted_total, output ready);
endinterface

// ----- rtl/core/tetra_volume_classifier_core.sv -----
// Top level of the tetrahedron volume classifier.
// Corners are taken one per request; the first three are stored, and the fourth starts a
// calculation of six times the signed volume on one shared multiplier that forms the nine
// products, followed by a magnitude step and a threshold compare step that registers the
// result. No corner is taken during that calculation, and a fourth corner waits until the
// previous result has been taken.
// A missing corner forces the volume to zero and sets bad_reference; start_of_mesh clears
// both saturating counts and makes its corner the first of a new group.
module tetra_volume_classifier_core #(
	parameter int COORD_WIDTH = tvc_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = tvc_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tvc_corner_if.sink corner,
	tvc_result_if.source result,
	input  logic cfg_write,
	input  logic [tvc_pkg::THR_W-1:0] cfg_wdata
);
	tvc_pkg::dp_cmd_t cmd;
	logic in_ready;
	logic out_valid;

	assign corner.ready = in_ready;
	assign result.valid = out_valid;

	tvc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(corner.valid),
		.in_ready(in_ready),
		.corner_present(corner.corner_present),
		.start_of_mesh(corner.start_of_mesh),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.cmd(cmd)
	);

	tvc_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.corner_x(corner.corner_x),
		.corner_y(corner.corner_y),
		.corner_z(corner.corner_z),
		.cfg_write(cfg_write),
		.cfg_wdata(cfg_wdata),
		.six_volume(result.six_volume),
		.is_degenerate(result.is_degenerate),
		.is_inverted(result.is_inverted),
		.bad_reference(result.bad_reference),
		.degenerate_total(result.degenerate_total),
		.inverted_total(result.inverted_total)
	);

endmodule

// ----- rtl/core/tvc_ctrl.sv -----
// Controller that tracks corner position and sequences the shared multiplier.
module tvc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic corner_present,
	input  logic start_of_mesh,
	output logic out_valid,
	input  logic out_ready,
	output tvc_pkg::dp_cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_MAG = 2'd2;
	localparam logic [1:0] ST_CLASS = 2'd3;
	localparam logic [3:0] LAST_STEP = 4'd12;

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic [1:0] pos_q;
	logic missing_q;
	logic out_valid_q;
	logic in_fire;
	logic [1:0] pos_eff;
	logic missing_eff;

	assign in_ready = (state_q == ST_IDLE) && !(out_valid_q && pos_q == tvc_pkg::POS_FOURTH);
	assign in_fire = in_valid && in_ready;
	assign pos_eff = start_of_mesh ? tvc_pkg::POS_FIRST : pos_q;
	assign missing_eff = (!start_of_mesh && missing_q) || !corner_present;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load_corner = in_fire;
		cmd.corner_sel = pos_eff;
		cmd.missing = missing_eff;
		cmd.clr_cnt = in_fire && start_of_mesh;
		cmd.mag_en = (state_q == ST_MAG);
		cmd.classify = (state_q == ST_CLASS);
		if (state_q == ST_CALC) begin
			unique case (step_q[1:0])
				2'd0: begin
					cmd.mul_en = (step_q != LAST_STEP);
					cmd.mul_sel = tvc_pkg::MUL_FIRST;
					cmd.vol_load = (step_q == 4'd4);
					cmd.vol_add = (step_q == 4'd8) || (step_q == LAST_STEP);
				end
				2'd1: begin
					cmd.cross_load = 1'b1;
					cmd.mul_en = 1'b1;
					cmd.mul_sel = tvc_pkg::MUL_SECOND;
				end
				2'd2: begin
					cmd.cross_sub = 1'b1;
				end
				default: begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = tvc_pkg::MUL_OUTER;
					cmd.rotate = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			pos_q <= tvc_pkg::POS_FIRST;
			missing_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (pos_eff == tvc_pkg::POS_FOURTH) begin
							pos_q <= tvc_pkg::POS_FIRST;
							missing_q <= 1'b0;
							step_q <= '0;
							state_q <= ST_CALC;
						end else begin
							pos_q <= pos_eff + 2'd1;
							missing_q <= missing_eff;
						end
					end
				end
				ST_CALC: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_MAG;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_MAG: begin
					state_q <= ST_CLASS;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_CLASS) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fourth_needs_free_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && pos_eff == tvc_pkg::POS_FOURTH) |-> !out_valid_q)
		else $error("fourth corner accepted while a result is pending");
	a_fourth_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && pos_eff == tvc_pkg::POS_FOURTH) |=> (state_q == ST_CALC && step_q == '0))
		else $error("fourth corner did not start the calculation");
	a_valid_after_class: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CLASS))
		else $error("result raised outside the classification step");
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (step_q <= LAST_STEP))
		else $error("calculation step out of range");
`endif

endmodule

// ----- rtl/core/tvc_datapath.sv -----
// Datapath with edge registers, the shared multiplier, classification and counters.
module tvc_datapath #(
	parameter int COORD_WIDTH = tvc_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = tvc_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  tvc_pkg::dp_cmd_t cmd,
	input  logic signed [COORD_WIDTH-1:0] corner_x,
	input  logic signed [COORD_WIDTH-1:0] corner_y,
	input  logic signed [COORD_WIDTH-1:0] corner_z,
	input  logic cfg_write,
	input  logic [tvc_pkg::THR_W-1:0] cfg_wdata,
	output logic signed [tvc_pkg::VOL_OUT_W-1:0] six_volume,
	output logic is_degenerate,
	output logic is_inverted,
	output logic bad_reference,
	output logic [tvc_pkg::TOTAL_W-1:0] degenerate_total,
	output logic [tvc_pkg::TOTAL_W-1:0] inverted_total
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int XW = 2 * EW + 1;
	localparam int PW = XW + EW;
	localparam int VW = PW + 2;
	localparam int OW = tvc_pkg::VOL_OUT_W;
	localparam int SW = (VW > OW) ? VW : OW;
	localparam int MW = (VW > tvc_pkg::THR_W) ? VW : tvc_pkg::THR_W;
	localparam logic signed [SW-1:0] VOL_HI = {{(SW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
	localparam logic signed [SW-1:0] VOL_LO = ~VOL_HI;

	logic signed [COORD_WIDTH-1:0] p [3];
	logic signed [COORD_WIDTH-1:0] h0_q [3];
	logic signed [EW-1:0] edge_new [3];
	logic signed [EW-1:0] a_q [3];
	logic signed [EW-1:0] b_q [3];
	logic signed [EW-1:0] c_q [3];
	logic bad_q;
	logic [tvc_pkg::THR_W-1:0] thr_q;
	logic signed [XW-1:0] mul_l;
	logic signed [EW-1:0] mul_r;
	logic signed [PW-1:0] prod_q;
	logic signed [XW-1:0] cross_q;
	logic signed [VW-1:0] vol_q;
	logic signed [VW-1:0] vol_e;
	logic signed [SW-1:0] vol_s;
	logic neg_q;
	logic [VW-1:0] mag_q;
	logic signed [OW-1:0] sixv_q;
	logic [MW-1:0] mag_e;
	logic [MW-1:0] thr_e;
	logic degen;
	logic inv;
	logic [COUNT_WIDTH-1:0] deg_cnt_q;
	logic [COUNT_WIDTH-1:0] inv_cnt_q;
	logic [COUNT_WIDTH-1:0] deg_next;
	logic [COUNT_WIDTH-1:0] inv_next;
	logic signed [OW-1:0] out_vol_q;
	logic out_degen_q;
	logic out_inv_q;
	logic out_bad_q;
	logic [tvc_pkg::TOTAL_W-1:0] out_deg_q;
	logic [tvc_pkg::TOTAL_W-1:0] out_inv_q2;

	assign p[0] = corner_x;
	assign p[1] = corner_y;
	assign p[2] = corner_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			edge_new[i] = $signed({p[i][COORD_WIDTH-1], p[i]})
				- $signed({h0_q[i][COORD_WIDTH-1], h0_q[i]});
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			tvc_pkg::MUL_FIRST: begin
				mul_l = {{(XW - EW){b_q[1][EW-1]}}, b_q[1]};
				mul_r = c_q[2];
			end
			tvc_pkg::MUL_SECOND: begin
				mul_l = {{(XW - EW){b_q[2][EW-1]}}, b_q[2]};
				mul_r = c_q[1];
			end
			tvc_pkg::MUL_OUTER: begin
				mul_l = cross_q;
				mul_r = a_q[0];
			end
			default: begin
				mul_l = '0;
				mul_r = '0;
			end
		endcase
	end

	assign vol_e = bad_q ? '0 : vol_q;
	assign vol_s = SW'(vol_e);
	assign mag_e = MW'(mag_q);
	assign thr_e = MW'(thr_q);
	assign degen = mag_e < thr_e;
	assign inv = neg_q && (mag_e > thr_e);
	assign deg_next = (degen && !(&deg_cnt_q)) ? deg_cnt_q + COUNT_WIDTH'(1) : deg_cnt_q;
	assign inv_next = (inv && !(&inv_cnt_q)) ? inv_cnt_q + COUNT_WIDTH'(1) : inv_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.load_corner) begin
			unique case (cmd.corner_sel)
				tvc_pkg::POS_FIRST: begin
					for (int i = 0; i < 3; i++) h0_q[i] <= p[i];
				end
				tvc_pkg::POS_SECOND: begin
					for (int i = 0; i < 3; i++) a_q[i] <= edge_new[i];
				end
				tvc_pkg::POS_THIRD: begin
					for (int i = 0; i < 3; i++) b_q[i] <= edge_new[i];
				end
				default: begin
					for (int i = 0; i < 3; i++) c_q[i] <= edge_new[i];
					bad_q <= cmd.missing;
				end
			endcase
		end
		if (cmd.rotate) begin
			a_q[0] <= a_q[1];
			a_q[1] <= a_q[2];
			a_q[2] <= a_q[0];
			b_q[0] <= b_q[1];
			b_q[1] <= b_q[2];
			b_q[2] <= b_q[0];
			c_q[0] <= c_q[1];
			c_q[1] <= c_q[2];
			c_q[2] <= c_q[0];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_l * mul_r;
		end
		if (cmd.cross_load) begin
			cross_q <= prod_q[XW-1:0];
		end else if (cmd.cross_sub) begin
			cross_q <= cross_q - prod_q[XW-1:0];
		end
		if (cmd.vol_load) begin
			vol_q <= {{2{prod_q[PW-1]}}, prod_q};
		end else if (cmd.vol_add) begin
			vol_q <= vol_q + {{2{prod_q[PW-1]}}, prod_q};
		end
		if (cmd.mag_en) begin
			neg_q <= vol_e[VW-1];
			mag_q <= vol_e[VW-1] ? VW'(-vol_e) : VW'(vol_e);
			if (vol_s > VOL_HI) begin
				sixv_q <= VOL_HI[OW-1:0];
			end else if (vol_s < VOL_LO) begin
				sixv_q <= VOL_LO[OW-1:0];
			end else begin
				sixv_q <= vol_s[OW-1:0];
			end
		end
		if (cmd.classify) begin
			out_vol_q <= sixv_q;
			out_degen_q <= degen;
			out_inv_q <= inv;
			out_bad_q <= bad_q;
			out_deg_q <= tvc_pkg::TOTAL_W'(deg_next);
			out_inv_q2 <= tvc_pkg::TOTAL_W'(inv_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tvc_pkg::THR_RESET;
			deg_cnt_q <= '0;
			inv_cnt_q <= '0;
		end else begin
			if (cfg_write) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.clr_cnt) begin
				deg_cnt_q <= '0;
				inv_cnt_q <= '0;
			end else if (cmd.classify) begin
				deg_cnt_q <= deg_next;
				inv_cnt_q <= inv_next;
			end
		end
	end

	assign six_volume = out_vol_q;
	assign is_degenerate = out_degen_q;
	assign is_inverted = out_inv_q;
	assign bad_reference = out_bad_q;
	assign degenerate_total = out_deg_q;
	assign inverted_total = out_inv_q2;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the tetrahedron volume classifier core.
`timescale 1ns / 100ps

module tb;

	localparam int CW = tvc_pkg::COORD_WIDTH_DEF;
	localparam int VW = tvc_pkg::VOL_OUT_W;
	localparam int TW = tvc_pkg::TOTAL_W;
	localparam int THW = tvc_pkg::THR_W;
	localparam longint VOL_TOP = (longint'(1) <<< (VW - 1)) - 1;
	localparam longint VOL_BOTTOM = -(longint'(1) <<< (VW - 1));

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic present;
		logic start;
	} corner_req_t;

	typedef struct {
		logic signed [VW-1:0] vol;
		logic degen;
		logic inv;
		logic bad;
		logic [TW-1:0] deg_total;
		logic [TW-1:0] inv_total;
	} volume_res_t;

	typedef enum {SHAPE_WIDE, SHAPE_TINY, SHAPE_EXTREME, SHAPE_FLAT} shape_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [THW-1:0] cfg_wdata;

	tvc_corner_if #(.COORD_WIDTH(CW)) corner_ch();
	tvc_result_if result_ch();

	tetra_volume_classifier_core #(
		.COORD_WIDTH(CW),
		.COUNT_WIDTH(tvc_pkg::COUNT_WIDTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.corner(corner_ch),
		.result(result_ch),
		.cfg_write(cfg_write),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	corner_req_t corner_backlog[$];
	volume_res_t volume_due[$];
	corner_req_t offered;
	volume_res_t seen;
	int failures = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int phase_no = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	logic hold_on = 1'b0;

	logic [THW-1:0] thr_now = tvc_pkg::THR_RESET;
	corner_req_t held [0:2];
	logic [1:0] slot = tvc_pkg::POS_FIRST;
	logic lost = 1'b0;
	logic [TW-1:0] deg_count = '0;
	logic [TW-1:0] inv_count = '0;

	task automatic take_corner(input corner_req_t c);
		longint a[3];
		longint b[3];
		longint d[3];
		longint vol;
		longint mag;
		longint thr;
		longint clamped;
		volume_res_t r;
		if (c.start) begin
			deg_count = '0;
			inv_count = '0;
			slot = tvc_pkg::POS_FIRST;
			lost = 1'b0;
		end
		if (!c.present) begin
			lost = 1'b1;
		end
		if (slot != tvc_pkg::POS_FOURTH) begin
			held[slot] = c;
			slot = slot + 2'd1;
			return;
		end
		a[0] = longint'(held[1].x) - longint'(held[0].x);
		a[1] = longint'(held[1].y) - longint'(held[0].y);
		a[2] = longint'(held[1].z) - longint'(held[0].z);
		b[0] = longint'(held[2].x) - longint'(held[0].x);
		b[1] = longint'(held[2].y) - longint'(held[0].y);
		b[2] = longint'(held[2].z) - longint'(held[0].z);
		d[0] = longint'(c.x) - longint'(held[0].x);
		d[1] = longint'(c.y) - longint'(held[0].y);
		d[2] = longint'(c.z) - longint'(held[0].z);
		if (lost) begin
			vol = 0;
		end else begin
			vol = a[0] * (b[1] * d[2] - b[2] * d[1])
				+ a[1] * (b[2] * d[0] - b[0] * d[2])
				+ a[2] * (b[0] * d[1] - b[1] * d[0]);
		end
		mag = (vol < 0) ? -vol : vol;
		thr = longint'(thr_now);
		r.degen = (mag < thr);
		r.inv = (vol < 0) && (mag > thr);
		if (r.degen && deg_count != '1) begin
			deg_count = deg_count + 1'b1;
		end
		if (r.inv && inv_count != '1) begin
			inv_count = inv_count + 1'b1;
		end
		clamped = (vol > VOL_TOP) ? VOL_TOP : ((vol < VOL_BOTTOM) ? VOL_BOTTOM : vol);
		r.vol = VW'(clamped);
		r.bad = lost;
		r.deg_total = deg_count;
		r.inv_total = inv_count;
		volume_due = {volume_due, r};
		slot = tvc_pkg::POS_FIRST;
		lost = 1'b0;
	endtask

	function automatic int draw_wait(bit idling);
		return idling ? int'($urandom_range(0, 4)) : 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_ch.valid <= 1'b0;
			corner_ch.corner_x <= '0;
			corner_ch.corner_y <= '0;
			corner_ch.corner_z <= '0;
			corner_ch.corner_present <= 1'b0;
			corner_ch.start_of_mesh <= 1'b0;
			tx_wait = 0;
		end else begin
			if (corner_ch.valid && corner_ch.ready) begin
				take_corner(offered);
				tx_wait = draw_wait(tx_idle);
			end
			if (!(corner_ch.valid && !corner_ch.ready)) begin
				if (tx_wait > 0) begin
					tx_wait--;
					corner_ch.valid <= 1'b0;
				end else if (corner_backlog.size() > 0) begin
					offered = corner_backlog.pop_front();
					corner_ch.valid <= 1'b1;
					corner_ch.corner_x <= offered.x;
					corner_ch.corner_y <= offered.y;
					corner_ch.corner_z <= offered.z;
					corner_ch.corner_present <= offered.present;
					corner_ch.start_of_mesh <= offered.start;
				end else begin
					corner_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_volume(input volume_res_t got);
		volume_res_t want;
		if (volume_due.size() == 0) begin
			$display("%0t: unexpected result, six_volume %0d", $time, got.vol);
			failures++;
			return;
		end
		want = volume_due.pop_front();
		if (got.vol !== want.vol) begin
			$display("%0t: six_volume expected %0d actual %0d", $time, want.vol, got.vol);
			failures++;
		end
		if (got.degen !== want.degen) begin
			$display("%0t: is_degenerate expected %0b actual %0b", $time, want.degen,
				got.degen);
			failures++;
		end
		if (got.inv !== want.inv) begin
			$display("%0t: is_inverted expected %0b actual %0b", $time, want.inv, got.inv);
			failures++;
		end
		if (got.bad !== want.bad) begin
			$display("%0t: bad_reference expected %0b actual %0b", $time, want.bad, got.bad);
			failures++;
		end
		if (got.deg_total !== want.deg_total) begin
			$display("%0t: degenerate_total expected %0d actual %0d", $time,
				want.deg_total, got.deg_total);
			failures++;
		end
		if (got.inv_total !== want.inv_total) begin
			$display("%0t: inverted_total expected %0d actual %0d", $time,
				want.inv_total, got.inv_total);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				seen.vol = result_ch.six_volume;
				seen.degen = result_ch.is_degenerate;
				seen.inv = result_ch.is_inverted;
				seen.bad = result_ch.bad_reference;
				seen.deg_total = result_ch.degenerate_total;
				seen.inv_total = result_ch.inverted_total;
				check_volume(seen);
				rx_wait = draw_wait(rx_idle);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			result_ch.ready <= (rx_wait == 0) && !hold_on;
		end
	end

	// The receiver blocks for a long stretch while the sender keeps going.
	initial begin
		wait (phase_no == 2);
		repeat (40) @(posedge clk);
		hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#2000000;
		$display("tetra_volume_classifier_core verification failed");
		$finish;
	end

	function automatic void queue_corner(int x, int y, int z, bit present, bit start);
		corner_req_t c;
		c.x = CW'(x);
		c.y = CW'(y);
		c.z = CW'(z);
		c.present = present;
		c.start = start;
		corner_backlog = {corner_backlog, c};
	endfunction

	function automatic int pick_coord(shape_t shape);
		int r;
		r = int'($urandom_range(0, 1));
		case (shape)
			SHAPE_TINY: begin
				return int'($urandom_range(0, 6)) - 3;
			end
			SHAPE_EXTREME: begin
				return ($urandom_range(0, 1) != 0) ? 32767 - r : -32768 + r;
			end
			default: begin
				return int'($urandom_range(0, 65535)) - 32768;
			end
		endcase
	endfunction

	function automatic void queue_group(shape_t shape, bit start);
		int plane;
		plane = pick_coord(SHAPE_WIDE);
		for (int k = 0; k < 4; k++) begin
			queue_corner(pick_coord(shape), pick_coord(shape),
				(shape == SHAPE_FLAT) ? plane : pick_coord(shape),
				$urandom_range(0, 11) != 0, start && k == 0);
		end
	endfunction

	// Mostly whole groups; sometimes a torn group, after which a start marker realigns.
	function automatic void queue_random(int target, bit tiny_heavy);
		int pushed;
		int n;
		bit cut;
		shape_t shape;
		pushed = 0;
		cut = 1'b0;
		while (pushed < target) begin
			if ($urandom_range(0, 9) == 0) begin
				n = int'($urandom_range(1, 3));
				repeat (n) begin
					queue_corner(pick_coord(SHAPE_WIDE), pick_coord(SHAPE_WIDE),
						pick_coord(SHAPE_WIDE), 1'($urandom_range(0, 1)),
						$urandom_range(0, 7) == 0);
				end
				pushed += n;
				cut = 1'b1;
			end else begin
				if (tiny_heavy && $urandom_range(0, 1) != 0) begin
					shape = SHAPE_TINY;
				end else begin
					shape = shape_t'($urandom_range(0, 3));
				end
				queue_group(shape, cut || $urandom_range(0, 15) == 0);
				pushed += 4;
				cut = 1'b0;
			end
		end
	endfunction

	task automatic drain_and_pause();
		while (corner_backlog.size() != 0 || corner_ch.valid || volume_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (24) @(negedge clk);
	endtask

	task automatic set_threshold(input logic [THW-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_wdata <= value;
		thr_now = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [THW-1:0] thr;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_corner(0, 0, 0, 1, 1);
		queue_corner(32767, 0, 0, 1, 0);
		queue_corner(0, 32767, 0, 1, 0);
		queue_corner(0, 0, 32767, 1, 0);
		queue_corner(-32768, -32768, -32768, 1, 0);
		queue_corner(32767, -32768, -32768, 1, 0);
		queue_corner(-32768, 32767, -32768, 1, 0);
		queue_corner(-32768, -32768, 32767, 1, 0);
		queue_corner(-32768, -32768, -32768, 1, 0);
		queue_corner(32767, -32768, -32768, 1, 0);
		queue_corner(-32768, -32768, 32767, 1, 0);
		queue_corner(-32768, 32767, -32768, 1, 0);
		queue_corner(0, 0, 0, 1, 0);
		queue_corner(1, 0, 0, 1, 0);
		queue_corner(0, 0, 1, 1, 0);
		queue_corner(0, 1, 0, 1, 0);
		queue_corner(32767, 32767, 32767, 1, 0);
		queue_corner(-32768, 32767, 0, 1, 0);
		queue_corner(-32768, -32768, -32768, 0, 0);
		queue_corner(32767, -32768, 32767, 1, 0);
		queue_corner(1, 2, 3, 1, 0);
		queue_corner(5, 5, 0, 1, 1);
		queue_corner(-7, 3, 0, 1, 0);
		queue_corner(100, -20, 0, 1, 0);
		queue_corner(0, 0, 0, 1, 0);
		drain_and_pause();

		for (int ph = 1; ph <= 6; ph++) begin
			case (ph)
				1: thr = '0;
				2: thr = '1;
				3: thr = THW'(6);
				4: thr = THW'({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
				5: thr = (THW'(1) << 44) + THW'($urandom);
				default: thr = THW'(1);
			endcase
			set_threshold(thr);
			@(negedge clk);
			tx_idle = (ph % 2 == 1);
			rx_idle = (ph % 4 >= 2);
			phase_no = ph;
			queue_random(325, ph == 3);
			drain_and_pause();
		end

		if (failures == 0) begin
			$display("tetra_volume_classifier_core verification clean");
		end else begin
			$display("tetra_volume_classifier_core verification failed");
		end
		$finish;
	end

endmodule
